@@ rtl/sawarq_pkg.sv @@
// Shared codes and transfer types for the stop-and-wait ARQ sequence engine.
// Used by sawarq_seq and by the top level stop_and_wait_arq_engine.
package sawarq_pkg;

  localparam int FIELD_SERIAL_WIDTH = 32;

  // Request types.
  localparam logic [1:0] REQ_TX_OPP = 2'd0;
  localparam logic [1:0] REQ_RX_FRAME = 2'd1;
  localparam logic [1:0] REQ_CLOSE = 2'd2;

  // Decoded kinds of a received frame.
  localparam logic [2:0] KIND_HANDSHAKE = 3'd0;
  localparam logic [2:0] KIND_CIAO = 3'd1;
  localparam logic [2:0] KIND_CHAT = 3'd2;
  localparam logic [2:0] KIND_CHAT_ACK = 3'd3;
  localparam logic [2:0] KIND_CHAT_NAK = 3'd4;

  // Actions placed in a result.
  localparam logic [2:0] ACT_NONE = 3'd0;
  localparam logic [2:0] ACT_RESEND = 3'd1;
  localparam logic [2:0] ACT_SEND_NEW = 3'd2;
  localparam logic [2:0] ACT_SEND_ACK = 3'd3;
  localparam logic [2:0] ACT_SEND_NAK = 3'd4;
  localparam logic [2:0] ACT_SEND_CIAO = 3'd5;

  typedef struct packed {
    logic [1:0] req_type;
    logic new_msg_ready;
    logic frame_ok;
    logic [2:0] frame_kind;
    logic [FIELD_SERIAL_WIDTH-1:0] rx_serial;
  } sawarq_item_t;

  typedef struct packed {
    logic [2:0] action;
    logic [FIELD_SERIAL_WIDTH-1:0] tx_serial;
    logic deliver;
    logic session_ended;
  } sawarq_result_t;

endpackage

@@ rtl/stop_and_wait_arq_engine.sv @@
// Top level of the stop-and-wait ARQ sequence engine: input register,
// result register and handshakes. Depends on sawarq_pkg and sawarq_seq.
//
// Usage:
// Each input transfer carries one event: a transmit opportunity, a received
// frame with its decoded kind and serial, or a local close request. Every
// event yields exactly one result transfer with an action, the serial to
// place in the outgoing frame, a deliver flag and a session-ended flag.
// Both channels use valid/ready. An accepted event is held in the input
// register, is evaluated against the serial state and lands in the result
// register. One event per cycle is sustained while the receiver takes each
// result; the limit is the single update of the serial registers per cycle.
// When the receiver stalls, the result register holds and the input
// register still takes one more event; after that in_ready drops until
// the result is taken. Serial state only advances when an event moves into
// the result register. Reset empties both registers and clears all serials
// and the outstanding frame. Serials are SERIAL_WIDTH bits wide and wrap;
// only the low SERIAL_WIDTH bits of rx_serial are used.
module stop_and_wait_arq_engine #(
  parameter int SERIAL_WIDTH = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [1:0] req_type,
  input  logic new_msg_ready,
  input  logic frame_ok,
  input  logic [2:0] frame_kind,
  input  logic [31:0] rx_serial,
  output logic out_valid,
  input  logic out_ready,
  output logic [2:0] action,
  output logic [31:0] tx_serial,
  output logic deliver,
  output logic session_ended
);
  import sawarq_pkg::*;

  logic s1_valid;
  sawarq_item_t s1_item;
  sawarq_result_t seq_result;
  sawarq_result_t out_result;
  logic advance;

  assign advance = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || !out_valid || out_ready;

  sawarq_seq #(
    .SERIAL_WIDTH(SERIAL_WIDTH)
  ) u_seq (
    .clk(clk),
    .rst(rst),
    .fire(advance),
    .item(s1_item),
    .result(seq_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item.req_type <= req_type;
      s1_item.new_msg_ready <= new_msg_ready;
      s1_item.frame_ok <= frame_ok;
      s1_item.frame_kind <= frame_kind;
      s1_item.rx_serial <= rx_serial;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= seq_result;
    end
  end

  assign action = out_result.action;
  assign tx_serial = out_result.tx_serial;
  assign deliver = out_result.deliver;
  assign session_ended = out_result.session_ended;

  // A closed session only ever reports no action or a ciao.
  a_end_action: assert property (@(posedge clk) disable iff (rst)
    out_valid && session_ended |-> (action == ACT_NONE || action == ACT_SEND_CIAO))
    else $error("session end with a frame action");

  // Delivery always comes with an ACK of that serial.
  a_deliver_ack: assert property (@(posedge clk) disable iff (rst)
    out_valid && deliver |-> (action == ACT_SEND_ACK))
    else $error("deliver without ACK");

  // No numbered frame is sent, so no serial is reported.
  a_idle_serial: assert property (@(posedge clk) disable iff (rst)
    out_valid && (action == ACT_NONE || action == ACT_SEND_CIAO) |-> (tx_serial == '0))
    else $error("serial on a result without a numbered frame");

  // The state advances only when the result register can take the event.
  a_advance: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("event evaluated without a result");

endmodule

@@ rtl/sawarq_seq.sv @@
// Serial-number state of the ARQ engine and the decision logic for one event.
// Depends on sawarq_pkg for the event and result types and the codes.
module sawarq_seq #(
  parameter int SERIAL_WIDTH = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic fire,
  input  sawarq_pkg::sawarq_item_t item,
  output sawarq_pkg::sawarq_result_t result
);
  import sawarq_pkg::*;

  logic [SERIAL_WIDTH-1:0] next_send_serial, next_send_serial_next;
  logic [SERIAL_WIDTH-1:0] expected_recv_serial, expected_recv_serial_next;
  logic [SERIAL_WIDTH-1:0] pending_serial, pending_serial_next;
  logic pending_valid, pending_valid_next;
  logic [SERIAL_WIDTH-1:0] ser;

  assign ser = item.rx_serial[SERIAL_WIDTH-1:0];

  always_comb begin
    next_send_serial_next = next_send_serial;
    expected_recv_serial_next = expected_recv_serial;
    pending_serial_next = pending_serial;
    pending_valid_next = pending_valid;
    result = '0;

    unique case (item.req_type)
      REQ_TX_OPP: begin
        if (pending_valid) begin
          result.action = ACT_RESEND;
          result.tx_serial = FIELD_SERIAL_WIDTH'(pending_serial);
        end else if (item.new_msg_ready) begin
          result.action = ACT_SEND_NEW;
          result.tx_serial = FIELD_SERIAL_WIDTH'(next_send_serial);
          pending_valid_next = 1'b1;
          pending_serial_next = next_send_serial;
          next_send_serial_next = next_send_serial + SERIAL_WIDTH'(1);
        end
      end
      REQ_RX_FRAME: begin
        if (item.frame_ok) begin
          unique case (item.frame_kind) inside
            KIND_HANDSHAKE, KIND_CIAO: begin
              next_send_serial_next = '0;
              expected_recv_serial_next = '0;
              pending_serial_next = '0;
              pending_valid_next = 1'b0;
              result.session_ended = 1'b1;
            end
            KIND_CHAT: begin
              if (ser > expected_recv_serial) begin
                result.action = ACT_SEND_NAK;
                result.tx_serial = FIELD_SERIAL_WIDTH'(expected_recv_serial);
              end else if (ser < expected_recv_serial) begin
                // Duplicate: acknowledge the last in-order serial again.
                result.action = ACT_SEND_ACK;
                result.tx_serial =
                  FIELD_SERIAL_WIDTH'(expected_recv_serial - SERIAL_WIDTH'(1));
              end else begin
                result.action = ACT_SEND_ACK;
                result.tx_serial = FIELD_SERIAL_WIDTH'(expected_recv_serial);
                result.deliver = 1'b1;
                expected_recv_serial_next = expected_recv_serial + SERIAL_WIDTH'(1);
              end
            end
            KIND_CHAT_ACK: begin
              if (pending_valid && (pending_serial <= ser)) begin
                pending_valid_next = 1'b0;
              end
            end
            KIND_CHAT_NAK: begin
              // A NAK above the outstanding serial acknowledges it implicitly.
              if (pending_valid && (pending_serial < ser)) begin
                pending_valid_next = 1'b0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      REQ_CLOSE: begin
        next_send_serial_next = '0;
        expected_recv_serial_next = '0;
        pending_serial_next = '0;
        pending_valid_next = 1'b0;
        result.action = ACT_SEND_CIAO;
        result.session_ended = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_send_serial <= '0;
      expected_recv_serial <= '0;
      pending_serial <= '0;
      pending_valid <= 1'b0;
    end else if (fire) begin
      next_send_serial <= next_send_serial_next;
      expected_recv_serial <= expected_recv_serial_next;
      pending_serial <= pending_serial_next;
      pending_valid <= pending_valid_next;
    end
  end

endmodule
